// ----- hw/rtl/htw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

  // Defaults for the top-level parameters
  localparam int SLOT_DEPTH_DEF    = 8;
  localparam int DAY_SLOTS_DEF     = 30;
  localparam int TIMER_ID_BITS_DEF = 8;

  // Fixed field widths
  localparam int ID_W     = 8;
  localparam int DELAY_W  = 22;
  localparam int MS_W     = 48;
  localparam int REM_W    = 17;
  localparam int IVL_W    = 16;
  localparam int PHYS_W   = 8;   // holds 144 + up to 64 day slots
  localparam int SIZE_W   = 7;
  localparam int FRONT_W  = 6;
  localparam int Q_W      = 6;
  localparam int RECIP_W  = 27;
  localparam int DIV_W    = 17;
  localparam int PROD_W   = DELAY_W + RECIP_W;
  localparam int QD_W     = DELAY_W + 1;
  localparam int TICK_W   = 32;

  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [IVL_W-1:0] IVL_RESET = 16'd1000;

  localparam int SECS  = 60;
  localparam int MINS  = 60;
  localparam int HOURS = 24;

  // Wheel indexes
  localparam logic [1:0] W_SEC  = 2'd0;
  localparam logic [1:0] W_MIN  = 2'd1;
  localparam logic [1:0] W_HOUR = 2'd2;
  localparam logic [1:0] W_DAY  = 2'd3;

  // Command and result codes
  localparam logic FUNC_TIME    = 1'b0;
  localparam logic FUNC_INSERT  = 1'b1;
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_INSERT  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic               func;
    logic [MS_W-1:0]    now_ms;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay_s;
    logic               periodic;
  } cmd_item_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] expired_or_inserted_id;
    status_t         status;
    logic            last;
  } res_item_t;

  typedef logic [3:0][FRONT_W-1:0] front_vec_t;

  // Slot lookup result
  typedef struct packed {
    logic              done;
    logic              reject;
    logic [PHYS_W-1:0] phys;
    logic [REM_W-1:0]  rem;
  } loc_t;

  function automatic logic [SIZE_W-1:0] wheel_size(input logic [1:0] w,
                                                   input logic [SIZE_W-1:0] days);
    logic [SIZE_W-1:0] r;
    unique case (w)
      W_SEC:   r = SIZE_W'(SECS);
      W_MIN:   r = SIZE_W'(MINS);
      W_HOUR:  r = SIZE_W'(HOURS);
      default: r = days;
    endcase
    return r;
  endfunction

  function automatic logic [PHYS_W-1:0] wheel_base(input logic [1:0] w);
    logic [PHYS_W-1:0] r;
    unique case (w)
      W_SEC:   r = PHYS_W'(0);
      W_MIN:   r = PHYS_W'(SECS);
      W_HOUR:  r = PHYS_W'(SECS + MINS);
      default: r = PHYS_W'(SECS + MINS + HOURS);
    endcase
    return r;
  endfunction

  // Seconds per slot of each wheel
  function automatic logic [DIV_W-1:0] divisor(input logic [1:0] w);
    logic [DIV_W-1:0] r;
    unique case (w)
      W_SEC:   r = DIV_W'(1);
      W_MIN:   r = DIV_W'(SECS);
      W_HOUR:  r = DIV_W'(SECS * MINS);
      default: r = DIV_W'(SECS * MINS * HOURS);
    endcase
    return r;
  endfunction

  // floor(2^32 / divisor); zero for the seconds wheel, whose quotient is the delay itself
  function automatic logic [RECIP_W-1:0] recip(input logic [1:0] w);
    logic [RECIP_W-1:0] r;
    unique case (w)
      W_SEC:   r = RECIP_W'(0);
      W_MIN:   r = RECIP_W'(71582788);
      W_HOUR:  r = RECIP_W'(1193046);
      default: r = RECIP_W'(49710);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hierarchical_timer_wheel_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Signals                    Dir  Moves
// cmd      cmd_valid/cmd_ready/cmd    in   one command item (time update or insert)
// res      res_valid/res_ready/res    out  one result item (expiry or insert status)
// cfg      cfg_we/cfg_wdata           in   tick interval in ms, no handshake
//
// Items are handled one at a time; cmd_ready is high only in idle. An insert holds the
// block while the slot locator pipeline and the registered count and entry memories place
// it; a zero delay goes straight to its result. On a tick, a time update pops the front
// slot of each wheel up to the highest that rolled over, reads its entries, then expires
// each due entry (re-arming a periodic one) and places the others again in lower wheels.
// Reset is synchronous and clears control state and the slot counts at once. A stalled
// result channel holds the sequencer at its next result.

module hierarchical_timer_wheel_top
  import htw_pkg::*;
#(
  parameter int SLOT_DEPTH    = SLOT_DEPTH_DEF,
  parameter int DAY_SLOTS     = DAY_SLOTS_DEF,
  parameter int TIMER_ID_BITS = TIMER_ID_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire cmd_item_t        cmd,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output res_item_t             res,
  input  wire logic             cfg_we,
  input  wire logic [IVL_W-1:0] cfg_wdata
);

  localparam int TOTAL   = SECS + MINS + HOURS + DAY_SLOTS;
  localparam int CNT_W   = $clog2(SLOT_DEPTH + 1);
  localparam int IDX_W   = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int EDEPTH  = TOTAL * SLOT_DEPTH;
  localparam int EADDR_W = $clog2(EDEPTH);
  localparam int CADDR_W = $clog2(TOTAL);
  localparam int IDS_W   = (TIMER_ID_BITS < ID_W) ? TIMER_ID_BITS : ID_W;
  localparam int EW      = IDS_W + 1 + DELAY_W + REM_W;
  localparam logic [SIZE_W-1:0] DAYS = SIZE_W'(DAY_SLOTS);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_INS     = 17'h00002,
    S_TCHK    = 17'h00004,
    S_POP_RD  = 17'h00008,
    S_POP_CNT = 17'h00010,
    S_POP_LD  = 17'h00020,
    S_POP_CAP = 17'h00040,
    S_PROC    = 17'h00080,
    S_REARM   = 17'h00100,
    S_PL_GO   = 17'h00200,
    S_PL_WAIT = 17'h00400,
    S_PL_CNT  = 17'h00800,
    S_PL_END  = 17'h01000,
    S_EMIT    = 17'h02000,
    S_NEXT    = 17'h04000,
    S_NXW     = 17'h08000,
    S_FLUSH   = 17'h10000
  } state_t;

  state_t                 state, ret;
  cmd_item_t              cmd_r;
  logic [IVL_W-1:0]       interval;
  logic [MS_W-1:0]        last_ms, last_eff;
  logic [TICK_W-1:0]      tick_count, tick_next;
  logic [5:0]             sec_m, min_m, sec_next, min_next;
  logic [4:0]             hr_m, hr_next;
  logic [1:0]             lvl_max, lvl_next, pw;
  logic                   do_tick;
  front_vec_t             fronts;
  logic [PHYS_W-1:0]      pop_phys, pl_phys, pop_phys_next;
  logic [CNT_W-1:0]       pop_n, j, j_inc;
  logic [EW-1:0]          held [SLOT_DEPTH];
  logic [EW-1:0]          cur;
  logic [IDS_W-1:0]       cur_id;
  logic                   cur_per;
  logic [DELAY_W-1:0]     cur_period;
  logic [REM_W-1:0]       cur_rem;
  logic [IDS_W-1:0]       pl_id;
  logic                   pl_per;
  logic [DELAY_W-1:0]     pl_period, pl_delay;
  logic [REM_W-1:0]       pl_rem;
  status_t                pl_st;
  logic                   ins_mode;
  logic                   em_kind;
  logic [IDS_W-1:0]       em_id;
  status_t                em_status;
  logic                   pend_valid;
  res_item_t              pend;
  res_item_t              pend_fin;
  logic                   res_load;
  logic [RES_CNT_W-1:0]   res_cnt;
  logic                   out_free;
  logic [IDS_W-1:0]       ins_id;

  logic                   loc_start;
  loc_t                   loc;
  logic                   cnt_rd_en, cnt_wr_en;
  logic [CADDR_W-1:0]     cnt_rd_addr, cnt_wr_addr;
  logic [CNT_W-1:0]       cnt_rd_data, cnt_wr_data;
  logic                   ent_rd_en, ent_wr_en;
  logic [EADDR_W-1:0]     ent_rd_addr, ent_wr_addr;
  logic [EW-1:0]          ent_rd_data, ent_wr_data;

  htw_locator #(.DAY_SLOTS(DAY_SLOTS)) u_locator (
    .clk    (clk),
    .rst    (rst),
    .start  (loc_start),
    .delay  (pl_delay),
    .fronts (fronts),
    .loc    (loc)
  );

  htw_count_ram #(.DEPTH(TOTAL), .WIDTH(CNT_W)) u_counts (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data)
  );

  htw_entry_ram #(.DEPTH(EDEPTH), .WIDTH(EW)) u_entries (
    .clk     (clk),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data)
  );

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign ins_id    = cmd_r.timer_id[IDS_W-1:0];
  assign j_inc     = j + CNT_W'(1);

  // Load the output register from the held-back result
  assign res_load = pend_valid && out_free &&
                    ((state == S_EMIT && res_cnt != RES_CNT_W'(MAX_RESULTS)) ||
                     state == S_FLUSH);

  // Final result of an item carries last
  always_comb begin
    pend_fin      = pend;
    pend_fin.last = 1'b1;
  end

  // Unpack the held entry under processing
  assign cur        = held[j[IDX_W-1:0]];
  assign cur_id     = cur[IDS_W-1:0];
  assign cur_per    = cur[IDS_W];
  assign cur_period = cur[IDS_W+1 +: DELAY_W];
  assign cur_rem    = cur[IDS_W+1+DELAY_W +: REM_W];

  assign pop_phys_next = wheel_base(pw) + PHYS_W'(fronts[pw]);

  // Tick decision and the tick phase counters
  always_comb begin
    last_eff  = (last_ms == '0) ? cmd_r.now_ms : last_ms;
    do_tick   = (cmd_r.now_ms >= last_eff) &&
                ((cmd_r.now_ms - last_eff) >= MS_W'(interval));
    tick_next = tick_count + TICK_W'(1);
    if (tick_next == '0) begin
      sec_next = '0;
      min_next = '0;
      hr_next  = '0;
    end else begin
      sec_next = (sec_m == 6'(SECS - 1)) ? '0 : sec_m + 6'(1);
      min_next = min_m;
      hr_next  = hr_m;
      if (sec_m == 6'(SECS - 1)) begin
        min_next = (min_m == 6'(MINS - 1)) ? '0 : min_m + 6'(1);
        if (min_m == 6'(MINS - 1)) begin
          hr_next = (hr_m == 5'(HOURS - 1)) ? '0 : hr_m + 5'(1);
        end
      end
    end
    priority if (sec_next == '0 && min_next == '0 && hr_next == '0) begin
      lvl_next = W_DAY;
    end else if (sec_next == '0 && min_next == '0) begin
      lvl_next = W_HOUR;
    end else if (sec_next == '0) begin
      lvl_next = W_MIN;
    end else begin
      lvl_next = W_SEC;
    end
  end

  // Memory port control
  always_comb begin
    loc_start   = (state == S_PL_GO);
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = CADDR_W'(pop_phys_next);
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = CADDR_W'(pop_phys);
    cnt_wr_data = '0;
    ent_rd_en   = (state == S_POP_LD);
    ent_rd_addr = EADDR_W'(pop_phys) * EADDR_W'(SLOT_DEPTH) + EADDR_W'(j);
    ent_wr_en   = 1'b0;
    ent_wr_addr = EADDR_W'(pl_phys) * EADDR_W'(SLOT_DEPTH) + EADDR_W'(cnt_rd_data);
    ent_wr_data = {pl_rem, pl_period, pl_per, pl_id};
    if (state == S_POP_RD) begin
      cnt_rd_en = 1'b1;
    end
    if (state == S_PL_WAIT && loc.done && !loc.reject) begin
      cnt_rd_en   = 1'b1;
      cnt_rd_addr = CADDR_W'(loc.phys);
    end
    if (state == S_POP_CNT) begin
      cnt_wr_en = 1'b1;
    end
    if (state == S_PL_CNT && cnt_rd_data < CNT_W'(SLOT_DEPTH)) begin
      cnt_wr_en   = 1'b1;
      cnt_wr_addr = CADDR_W'(pl_phys);
      cnt_wr_data = cnt_rd_data + CNT_W'(1);
      ent_wr_en   = 1'b1;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= IVL_RESET;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  // Payload held across the sequence
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
    if (state == S_POP_CAP) begin
      held[j[IDX_W-1:0]] <= ent_rd_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      last_ms    <= '0;
      tick_count <= '0;
      sec_m      <= '0;
      min_m      <= '0;
      hr_m       <= '0;
      lvl_max    <= W_SEC;
      pw         <= W_SEC;
      fronts     <= '0;
      j          <= '0;
      pop_n      <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
      res_cnt    <= '0;
      ins_mode   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res_cnt <= '0;
            state   <= (cmd.func == FUNC_INSERT) ? S_INS : S_TCHK;
          end
        end
        S_INS: begin
          pl_id     <= ins_id;
          pl_delay  <= cmd_r.delay_s;
          pl_period <= cmd_r.delay_s;
          pl_per    <= cmd_r.periodic;
          ins_mode  <= 1'b1;
          if (cmd_r.delay_s == '0) begin
            em_kind   <= KIND_INSERT;
            em_id     <= ins_id;
            em_status <= ST_ZERO;
            ret       <= S_FLUSH;
            state     <= S_EMIT;
          end else begin
            state <= S_PL_GO;
          end
        end
        S_TCHK: begin
          ins_mode <= 1'b0;
          if (last_ms == '0 || do_tick) begin
            last_ms <= cmd_r.now_ms;
          end
          if (do_tick) begin
            tick_count <= tick_next;
            sec_m      <= sec_next;
            min_m      <= min_next;
            hr_m       <= hr_next;
            lvl_max    <= lvl_next;
            pw         <= W_SEC;
            state      <= S_POP_RD;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_POP_RD: begin
          pop_phys <= pop_phys_next;
          state    <= S_POP_CNT;
        end
        S_POP_CNT: begin
          // Clear the front slot and rotate the wheel
          pop_n <= cnt_rd_data;
          j     <= '0;
          if (SIZE_W'(fronts[pw]) + SIZE_W'(1) == wheel_size(pw, DAYS)) begin
            fronts[pw] <= '0;
          end else begin
            fronts[pw] <= fronts[pw] + FRONT_W'(1);
          end
          state <= (cnt_rd_data == '0) ? S_NXW : S_POP_LD;
        end
        S_POP_LD: begin
          state <= S_POP_CAP;
        end
        S_POP_CAP: begin
          if (j_inc == pop_n) begin
            j     <= '0;
            state <= S_PROC;
          end else begin
            j     <= j_inc;
            state <= S_POP_LD;
          end
        end
        S_PROC: begin
          pl_id     <= cur_id;
          pl_per    <= cur_per;
          pl_period <= cur_period;
          pl_delay  <= DELAY_W'(cur_rem);
          if (pw == W_SEC || cur_rem == '0) begin
            em_kind   <= KIND_EXPIRED;
            em_id     <= cur_id;
            em_status <= ST_OK;
            ret       <= cur_per ? S_REARM : S_NEXT;
            state     <= S_EMIT;
          end else begin
            state <= S_PL_GO;
          end
        end
        S_REARM: begin
          if (pl_period == '0) begin
            em_kind   <= KIND_INSERT;
            em_id     <= pl_id;
            em_status <= ST_ZERO;
            ret       <= S_NEXT;
            state     <= S_EMIT;
          end else begin
            pl_delay <= pl_period;
            pl_per   <= 1'b1;
            state    <= S_PL_GO;
          end
        end
        S_PL_GO: begin
          state <= S_PL_WAIT;
        end
        S_PL_WAIT: begin
          if (loc.done) begin
            if (loc.reject) begin
              pl_st <= ST_RANGE;
              state <= S_PL_END;
            end else begin
              pl_phys <= loc.phys;
              pl_rem  <= loc.rem;
              state   <= S_PL_CNT;
            end
          end
        end
        S_PL_CNT: begin
          pl_st <= (cnt_rd_data < CNT_W'(SLOT_DEPTH)) ? ST_OK : ST_FULL;
          state <= S_PL_END;
        end
        S_PL_END: begin
          em_kind   <= KIND_INSERT;
          em_id     <= pl_id;
          em_status <= pl_st;
          if (ins_mode) begin
            ret   <= S_FLUSH;
            state <= S_EMIT;
          end else if (pl_st != ST_OK) begin
            ret   <= S_NEXT;
            state <= S_EMIT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_EMIT: begin
          // Hold back one result so the final one can carry last
          if (res_cnt == RES_CNT_W'(MAX_RESULTS)) begin
            state <= ret;
          end else if (!(pend_valid && !out_free)) begin
            if (pend_valid) begin
              res <= pend;
            end
            pend.kind                   <= em_kind;
            pend.expired_or_inserted_id <= ID_W'(em_id);
            pend.status                 <= em_status;
            pend.last                   <= 1'b0;
            pend_valid                  <= 1'b1;
            res_cnt                     <= res_cnt + RES_CNT_W'(1);
            state                       <= ret;
          end
        end
        S_NEXT: begin
          if (j_inc < pop_n) begin
            j     <= j_inc;
            state <= S_PROC;
          end else begin
            state <= S_NXW;
          end
        end
        S_NXW: begin
          if (pw < lvl_max) begin
            pw    <= pw + 2'd1;
            state <= S_POP_RD;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res        <= pend_fin;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PL_CNT |-> cnt_rd_data <= CNT_W'(SLOT_DEPTH))
    else $error("slot count above slot depth");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !pend_valid)
    else $error("new item taken with a result still held back");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count beyond cap");

  a_load_order: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_CAP |-> $past(state) == S_POP_LD)
    else $error("entry captured without a read issued");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/htw_count_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module htw_count_ram #(
  parameter int DEPTH = 174,
  parameter int WIDTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_q;
  logic             rd_v;

  // Write counts and mark entries as written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
      rd_v <= vld[rd_addr];
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/htw_entry_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module htw_entry_ram #(
  parameter int DEPTH = 1392,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/htw_locator.sv -----
`timescale 1ns / 1ps
`default_nettype none

module htw_locator
  import htw_pkg::*;
#(
  parameter int DAY_SLOTS = DAY_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DELAY_W-1:0] delay,
  input  wire front_vec_t         fronts,
  output loc_t                    loc
);

  localparam logic [SIZE_W-1:0] DAYS = SIZE_W'(DAY_SLOTS);

  logic [3:0]         v;
  logic [1:0]         w0, w1, w2, w3, w4;
  logic [DELAY_W-1:0] dly1, dly2, dly3;
  logic [PROD_W-1:0]  prod2;
  logic [Q_W-1:0]     q0, q3;
  logic [QD_W-1:0]    qd3, r3;
  logic [SIZE_W-1:0]  q4, s4, sum4, sum4_wrap, size4;
  logic [REM_W-1:0]   rem4;

  // Pick the wheel by delay range
  always_comb begin
    priority if (delay < DELAY_W'(SECS)) begin
      w0 = W_SEC;
    end else if (delay < DELAY_W'(SECS * MINS)) begin
      w0 = W_MIN;
    end else if (delay < DELAY_W'(SECS * MINS * HOURS)) begin
      w0 = W_HOUR;
    end else begin
      w0 = W_DAY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], start};
    end
  end

  // Quotient estimate by reciprocal (the delay itself on the seconds wheel), then one correction step
  assign q0 = (w2 == W_SEC) ? dly2[Q_W-1:0] : prod2[32 +: Q_W];
  assign r3 = QD_W'(dly3) - qd3;

  // Slot position relative to the wheel front
  assign s4        = q4 - SIZE_W'(1);
  assign sum4      = SIZE_W'(fronts[w4]) + s4;
  assign size4     = wheel_size(w4, DAYS);
  assign sum4_wrap = (sum4 >= size4) ? sum4 - size4 : sum4;

  always_ff @(posedge clk) begin
    dly1  <= delay;
    w1    <= w0;
    prod2 <= PROD_W'(dly1) * PROD_W'(recip(w1));
    dly2  <= dly1;
    w2    <= w1;
    qd3   <= QD_W'(q0) * QD_W'(divisor(w2));
    q3    <= q0;
    dly3  <= dly2;
    w3    <= w2;
    if (r3 >= QD_W'(divisor(w3))) begin
      q4   <= SIZE_W'(q3) + SIZE_W'(1);
      rem4 <= REM_W'(r3 - QD_W'(divisor(w3)));
    end else begin
      q4   <= SIZE_W'(q3);
      rem4 <= REM_W'(r3);
    end
    w4         <= w3;
    loc.reject <= (w4 == W_DAY) && (q4 > DAYS);
    loc.phys   <= wheel_base(w4) + PHYS_W'(sum4_wrap);
    loc.rem    <= rem4;
    if (rst) begin
      loc.done <= 1'b0;
    end else begin
      loc.done <= v[3];
    end
  end

endmodule

`default_nettype wire
